/* design/aob_pkg.sv */
package aob_pkg;

  // Channel and arithmetic widths.
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned PROD_W       = 2 * CHAN_W;
  localparam int unsigned NUM_CHAN     = 3;
  localparam int unsigned FULL_ALPHA   = 255;

  // The back end is one numerator stage followed by one restoring
  // division stage per quotient bit.
  localparam int unsigned QUOT_W       = CHAN_W;
  localparam int unsigned BACK_STAGES  = QUOT_W + 1;
  localparam int unsigned BACK_CNT_W   = $clog2(BACK_STAGES + 1);

  // Front end has two pipeline stages.
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned FRONT_CNT_W  = $clog2(FRONT_STAGES + 1);

  // Default queue depths.
  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 16;

  localparam logic BLEND_EN_RST = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t src;
    rgba_t dst;
  } pair_t;

  // A classified job handed from the front end to the back end.
  typedef struct packed {
    logic              copy;
    logic [CHAN_W-1:0] oa;
    logic [CHAN_W-1:0] res_alpha;
    rgba_t             src;
    rgba_t             dst;
  } job_t;

endpackage

/* design/aob_fifo.sv */
module aob_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

endmodule

/* design/aob_front.sv */
module aob_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              blend_enable,
  input  logic                              i_valid,
  input  aob_pkg::pair_t                    i_pair,
  output logic                              o_valid,
  output aob_pkg::job_t                     o_job,
  output logic [aob_pkg::FRONT_CNT_W-1:0]   occupancy
);

  localparam int unsigned CW = aob_pkg::CHAN_W;
  localparam int unsigned PW = aob_pkg::PROD_W;

  // Stage A: sa * da.
  logic                a_valid_r;
  aob_pkg::pair_t      a_pair_r;
  logic                a_en_r;
  logic [PW-1:0]       a_prod_r;

  // Stage B: output alpha and classification.
  logic                b_valid_r;
  aob_pkg::job_t       b_job_r;
  aob_pkg::job_t       b_job_nxt;

  logic [PW+CW-1:0]    scaled;
  logic [CW-1:0]       q_est;
  logic [PW-1:0]       rem;
  logic [CW-1:0]       q_div;
  logic [CW:0]         oa_sum;
  logic [CW-1:0]       oa;

  // floor(p / 255) as (p * 257) >> 16, which is low by at most one.
  always_comb begin
    scaled = {a_prod_r, {CW{1'b0}}} + (PW+CW)'(a_prod_r);
    q_est  = scaled[PW+CW-1:PW];
    rem    = a_prod_r - (PW'({q_est, {CW{1'b0}}}) - PW'(q_est));
    q_div  = (rem >= PW'(aob_pkg::FULL_ALPHA)) ? q_est + CW'(1) : q_est;
    oa_sum = (CW+1)'(a_pair_r.src.alpha) + (CW+1)'(a_pair_r.dst.alpha) - (CW+1)'(q_div);
    oa     = oa_sum[CW-1:0];

    b_job_nxt.src       = a_pair_r.src;
    b_job_nxt.dst       = a_pair_r.dst;
    b_job_nxt.oa        = oa;
    b_job_nxt.copy      = !a_en_r || (oa == '0);
    b_job_nxt.res_alpha = a_en_r ? oa : a_pair_r.src.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= i_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_pair_r <= i_pair;
    a_en_r   <= blend_enable;
    a_prod_r <= PW'(i_pair.src.alpha) * PW'(i_pair.dst.alpha);
    b_job_r  <= b_job_nxt;
  end

  assign o_valid   = b_valid_r;
  assign o_job     = b_job_r;
  assign occupancy = aob_pkg::FRONT_CNT_W'(a_valid_r) + aob_pkg::FRONT_CNT_W'(b_valid_r);

endmodule

/* design/aob_back.sv */
module aob_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             i_valid,
  input  aob_pkg::job_t                    i_job,
  output logic                             o_valid,
  output aob_pkg::rgba_t                   o_pix,
  output logic [aob_pkg::BACK_CNT_W-1:0]   inflight
);

  localparam int unsigned CW = aob_pkg::CHAN_W;
  localparam int unsigned PW = aob_pkg::PROD_W;
  localparam int unsigned NC = aob_pkg::NUM_CHAN;
  localparam int unsigned QW = aob_pkg::QUOT_W;
  localparam int unsigned NS = aob_pkg::BACK_STAGES;

  logic [NS-1:0] v_r;
  logic [PW-1:0] rem_r   [0:NS-1][0:NC-1];
  logic [QW-1:0] quot_r  [0:NS-1][0:NC-1];
  logic [CW-1:0] div_r   [0:NS-1];
  logic [CW-1:0] alpha_r [0:NS-1];

  logic [CW-1:0] s_c [0:NC-1];
  logic [CW-1:0] d_c [0:NC-1];
  logic [CW-1:0] w_dst;
  logic [PW-1:0] num_nxt [0:NC-1];
  logic [CW-1:0] div_nxt;

  assign s_c[0] = i_job.src.red;
  assign s_c[1] = i_job.src.green;
  assign s_c[2] = i_job.src.blue;
  assign d_c[0] = i_job.dst.red;
  assign d_c[1] = i_job.dst.green;
  assign d_c[2] = i_job.dst.blue;

  // Numerator stage. A copy job divides the source colour by one.
  always_comb begin
    w_dst   = i_job.oa - i_job.src.alpha;
    div_nxt = i_job.copy ? CW'(1) : i_job.oa;
    for (int k = 0; k < NC; k++) begin
      if (i_job.copy) begin
        num_nxt[k] = PW'(s_c[k]);
      end else begin
        num_nxt[k] = PW'(s_c[k]) * PW'(i_job.src.alpha) + PW'(d_c[k]) * PW'(w_dst);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    div_r[0]   <= div_nxt;
    alpha_r[0] <= i_job.res_alpha;
    for (int k = 0; k < NC; k++) begin
      rem_r[0][k]  <= num_nxt[k];
      quot_r[0][k] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  // The numerator is below 256 times the divisor, so eight bits suffice.
  for (genvar g = 1; g < NS; g++) begin : g_div
    localparam int unsigned BIT = QW - g;

    logic [PW-1:0] dsh;
    logic [PW-1:0] rem_nxt  [0:NC-1];
    logic [QW-1:0] quot_nxt [0:NC-1];

    assign dsh = PW'(div_r[g-1]) << BIT;

    always_comb begin
      for (int k = 0; k < NC; k++) begin
        if (rem_r[g-1][k] >= dsh) begin
          rem_nxt[k]  = rem_r[g-1][k] - dsh;
          quot_nxt[k] = quot_r[g-1][k] | (QW'(1) << BIT);
        end else begin
          rem_nxt[k]  = rem_r[g-1][k];
          quot_nxt[k] = quot_r[g-1][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      div_r[g]   <= div_r[g-1];
      alpha_r[g] <= alpha_r[g-1];
      for (int k = 0; k < NC; k++) begin
        rem_r[g][k]  <= rem_nxt[k];
        quot_r[g][k] <= quot_nxt[k];
      end
    end
  end

  assign o_valid     = v_r[NS-1];
  assign o_pix.red   = quot_r[NS-1][0];
  assign o_pix.green = quot_r[NS-1][1];
  assign o_pix.blue  = quot_r[NS-1][2];
  assign o_pix.alpha = alpha_r[NS-1];
  assign inflight    = aob_pkg::BACK_CNT_W'($countones(v_r));

endmodule

/* design/rgba_alpha_over_blend.sv */
// An accepted input word goes through the front end, the job queue, the back end and the
// result queue before its result shows (out_empty low). Throughput: one word per cycle
// sustained while the result queue is drained; the pipelines never stall, and the rate is
// set only by the queue credits (powers of two, MID_DEPTH 4 or more, OUT_DEPTH above 10).
// Reset (rst_n low at a clock edge) empties both queues and the pipelines
// and sets blend_enable to 1.
module rgba_alpha_over_blend #(
  parameter int unsigned MID_DEPTH = aob_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = aob_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_src_red,
  input  logic [7:0] in_src_green,
  input  logic [7:0] in_src_blue,
  input  logic [7:0] in_src_alpha,
  input  logic [7:0] in_dst_red,
  input  logic [7:0] in_dst_green,
  input  logic [7:0] in_dst_blue,
  input  logic [7:0] in_dst_alpha,

  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_opacity,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_blend_enable
);

  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned MID_SUM_W = MID_CNT_W + aob_pkg::FRONT_CNT_W;
  localparam int unsigned OUT_SUM_W = OUT_CNT_W + aob_pkg::BACK_CNT_W;

  // The blend enable register. Writes are always taken; the register is
  // sampled as each word enters the front end.
  logic blend_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_en_r <= aob_pkg::BLEND_EN_RST;
    end else if (cfg_valid && cfg_ready) begin
      blend_en_r <= cfg_blend_enable;
    end
  end

  assign cfg_ready = 1'b1;

  // Front end: the alpha product, the division by 255 and the choice
  // between a blend and a plain copy of the source colours.
  aob_pkg::pair_t                   in_pair;
  logic                             in_accept;
  logic                             front_valid;
  aob_pkg::job_t                    front_job;
  logic [aob_pkg::FRONT_CNT_W-1:0]  front_cnt;

  assign in_pair.src.red   = in_src_red;
  assign in_pair.src.green = in_src_green;
  assign in_pair.src.blue  = in_src_blue;
  assign in_pair.src.alpha = in_src_alpha;
  assign in_pair.dst.red   = in_dst_red;
  assign in_pair.dst.green = in_dst_green;
  assign in_pair.dst.blue  = in_dst_blue;
  assign in_pair.dst.alpha = in_dst_alpha;

  assign in_accept = in_push && !in_full;

  aob_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .blend_enable (blend_en_r),
    .i_valid      (in_accept),
    .i_pair       (in_pair),
    .o_valid      (front_valid),
    .o_job        (front_job),
    .occupancy    (front_cnt)
  );

  // The job queue between front and back. The front end takes a word only
  // while every word already in its pipeline is sure of a slot here.
  aob_pkg::job_t         mid_job;
  logic [MID_CNT_W-1:0]  mid_count;
  logic                  mid_full;
  logic                  mid_empty;
  logic                  issue;
  logic [MID_SUM_W-1:0]  mid_load;

  aob_fifo #(
    .WIDTH ($bits(aob_pkg::job_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_valid),
    .wdata (front_job),
    .pop   (issue),
    .rdata (mid_job),
    .count (mid_count),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign mid_load = MID_SUM_W'(front_cnt) + MID_SUM_W'(mid_count);
  assign in_full  = (mid_load >= MID_SUM_W'(MID_DEPTH));

  // Back end: the weighted colour numerators and the pipelined divider.
  // A job is issued only when the result queue can hold it together with
  // every word still in the divider.
  logic                            back_valid;
  aob_pkg::rgba_t                  back_pix;
  logic [aob_pkg::BACK_CNT_W-1:0]  back_cnt;
  logic [OUT_CNT_W-1:0]            out_count;
  logic                            out_full;
  logic [OUT_SUM_W-1:0]            out_load;
  aob_pkg::rgba_t                  out_pix;

  assign out_load = OUT_SUM_W'(back_cnt) + OUT_SUM_W'(out_count);
  assign issue    = !mid_empty && (out_load < OUT_SUM_W'(OUT_DEPTH));

  aob_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (issue),
    .i_job    (mid_job),
    .o_valid  (back_valid),
    .o_pix    (back_pix),
    .inflight (back_cnt)
  );

  aob_fifo #(
    .WIDTH ($bits(aob_pkg::rgba_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_valid),
    .wdata (back_pix),
    .pop   (out_pop && !out_empty),
    .rdata (out_pix),
    .count (out_count),
    .full  (out_full),
    .empty (out_empty)
  );

  assign out_red     = out_pix.red;
  assign out_green   = out_pix.green;
  assign out_blue    = out_pix.blue;
  assign out_opacity = out_pix.alpha;

  // The credit checks must keep both queues from overflowing.
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid |-> !mid_full)
    else $error("job queue written while full");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    back_valid |-> !out_full)
    else $error("result queue written while full");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("block not empty after reset");

  a_issue_credit: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (OUT_SUM_W'(back_cnt) + OUT_SUM_W'(out_count)) <= OUT_SUM_W'(OUT_DEPTH))
    else $error("result credit exceeded");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  // Cycles to let pass after the last result before the block counts as idle.
  localparam int unsigned SETTLE_CYCLES = 16;

  // Sender burst bounds, in words, and gap bounds, in cycles.
  localparam int unsigned BURST_MAX = 12;
  localparam int unsigned GAP_MAX   = 8;

  // Receiver stall patterns; the monitor switches between them at random.
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_COIN,
    POP_SPARSE,
    POP_CADENCE
  } pop_mode_t;
  localparam int unsigned POP_MODE_SPAN = 64;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;

  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_src_red = '0;
  logic [7:0] in_src_green = '0;
  logic [7:0] in_src_blue = '0;
  logic [7:0] in_src_alpha = '0;
  logic [7:0] in_dst_red = '0;
  logic [7:0] in_dst_green = '0;
  logic [7:0] in_dst_blue = '0;
  logic [7:0] in_dst_alpha = '0;

  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_opacity;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_blend_enable = 1'b0;

  rgba_alpha_over_blend dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_src_red       (in_src_red),
    .in_src_green     (in_src_green),
    .in_src_blue      (in_src_blue),
    .in_src_alpha     (in_src_alpha),
    .in_dst_red       (in_dst_red),
    .in_dst_green     (in_dst_green),
    .in_dst_blue      (in_dst_blue),
    .in_dst_alpha     (in_dst_alpha),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_opacity      (out_opacity),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_blend_enable (cfg_blend_enable)
  );

  // Period of 12 ns: six high, six low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pixel pairs waiting to be sent, and composited pixels waiting to come
  // back, oldest first.
  aob_pkg::pair_t pairs_to_send[$];
  aob_pkg::rgba_t composited_due[$];

  // Our own copy of the blend switch; it follows every accepted write.
  logic blend_mirror = aob_pkg::BLEND_EN_RST;

  aob_pkg::pair_t cur_pair;
  aob_pkg::rgba_t want;
  int unsigned    burst_left = 1;
  int unsigned    gap_left = 0;
  pop_mode_t      pop_mode = POP_ALWAYS;
  int unsigned    pop_tick = 0;

  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned copied_count = 0;
  int unsigned checked_count = 0;
  int unsigned cfg_write_count = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // One colour channel of the over operator: the mean of the source and
  // destination colours weighted by sa and (oa - sa). With both alphas zero
  // the output alpha is zero and the source colour is kept.
  function automatic logic [7:0] weigh_channel(input logic [7:0] s, input logic [7:0] d,
                                               input int unsigned sa, input int unsigned oa);
    int unsigned acc;
    if (oa == 0) return s;
    acc = (s * sa + d * (oa - sa)) / oa;
    return acc[7:0];
  endfunction

  // Expected result for one pixel pair under the given blend switch.
  function automatic aob_pkg::rgba_t compose_pixel(input aob_pkg::pair_t px,
                                                   input logic blend_on);
    aob_pkg::rgba_t res;
    int unsigned    sa;
    int unsigned    da;
    int unsigned    oa;
    if (!blend_on) return px.src;
    sa = px.src.alpha;
    da = px.dst.alpha;
    oa = sa + da - (sa * da) / aob_pkg::FULL_ALPHA;
    res.alpha = oa[7:0];
    res.red   = weigh_channel(px.src.red, px.dst.red, sa, oa);
    res.green = weigh_channel(px.src.green, px.dst.green, sa, oa);
    res.blue  = weigh_channel(px.src.blue, px.dst.blue, sa, oa);
    return res;
  endfunction

  function automatic aob_pkg::pair_t make_pair(input logic [7:0] sr, input logic [7:0] sg,
                                               input logic [7:0] sb, input logic [7:0] sa,
                                               input logic [7:0] dr, input logic [7:0] dg,
                                               input logic [7:0] db, input logic [7:0] da);
    aob_pkg::pair_t px;
    px.src = '{red: sr, green: sg, blue: sb, alpha: sa};
    px.dst = '{red: dr, green: dg, blue: db, alpha: da};
    return px;
  endfunction

  // Alphas lean towards the edges (transparent, opaque and their neighbours)
  // where the division is most likely to go wrong; the rest are uniform.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic aob_pkg::pair_t random_pair();
    return make_pair(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(),
                     8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
  endfunction

  // Driver. A word is taken at an edge where push is high and full is low;
  // at that edge its expected result is worked out with the blend switch as
  // it stands. The next word goes out when the slot is free and the current
  // burst has not run into a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        composited_due.push_back(compose_pixel(cur_pair, blend_mirror));
        sent_count++;
        if (!blend_mirror) copied_count++;
      end
      if (!in_push || !in_full) begin
        if (gap_left != 0) begin
          gap_left--;
          in_push <= 1'b0;
        end else if (pairs_to_send.size() != 0) begin
          cur_pair = pairs_to_send.pop_front();
          in_src_red   <= cur_pair.src.red;
          in_src_green <= cur_pair.src.green;
          in_src_blue  <= cur_pair.src.blue;
          in_src_alpha <= cur_pair.src.alpha;
          in_dst_red   <= cur_pair.dst.red;
          in_dst_green <= cur_pair.dst.green;
          in_dst_blue  <= cur_pair.dst.blue;
          in_dst_alpha <= cur_pair.dst.alpha;
          in_push      <= 1'b1;
          if (burst_left <= 1) begin
            // A quarter of the bursts run straight on with no gap, so long
            // back-to-back stretches occur as well.
            burst_left = $urandom_range(1, BURST_MAX);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
          end else begin
            burst_left--;
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor. A word is taken at an edge where pop is high and empty is low,
  // and is checked field by field against the oldest expected pixel. The
  // pop pattern changes every so often between always ready, a coin toss,
  // mostly stalled and a fixed stall-then-drain cadence.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (composited_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d a=%0d",
                                  out_red, out_green, out_blue, out_opacity));
      end else begin
        want = composited_due.pop_front();
        if (out_red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", out_blue, want.blue));
        if (out_opacity !== want.alpha)
          report_mismatch($sformatf("alpha %0d, expected %0d", out_opacity, want.alpha));
        checked_count++;
      end
    end
    pop_tick++;
    if (pop_tick % POP_MODE_SPAN == 0) pop_mode = pop_mode_t'($urandom_range(0, 3));
    case (pop_mode)
      POP_ALWAYS:  out_pop <= 1'b1;
      POP_COIN:    out_pop <= 1'($urandom_range(0, 1));
      POP_SPARSE:  out_pop <= ($urandom_range(0, 5) == 0);
      default:     out_pop <= ((pop_tick % 16) >= 10);
    endcase
  end

  // Waits until every queued word has gone in and every result has come
  // back, then lets the pipeline settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pairs_to_send.size() != 0 || in_push || composited_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the blend switch; only called while the block is idle.
  task automatic write_blend(input logic value);
    @(posedge clk);
    cfg_blend_enable <= value;
    cfg_valid        <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    blend_mirror = value;
    cfg_valid <= 1'b0;
    cfg_write_count++;
  endtask

  // Queues a batch of random pairs from the falling edge, away from the
  // driver's edge.
  task automatic queue_random(input int unsigned count);
    @(negedge clk);
    repeat (count) pairs_to_send.push_back(random_pair());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset setting (blending on): both alphas
    // zero, which must copy the source colours; opaque and transparent
    // sources over opaque and transparent destinations; alphas of one; and
    // alternating bit patterns in every field.
    @(negedge clk);
    pairs_to_send.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pairs_to_send.push_back(make_pair(8'hff, 8'h80, 8'h01, 8'h00, 8'h00, 8'h7f, 8'hfe, 8'h00));
    pairs_to_send.push_back(make_pair(8'haa, 8'h55, 8'hc3, 8'h00, 8'h55, 8'haa, 8'h3c, 8'h00));
    pairs_to_send.push_back(make_pair(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    pairs_to_send.push_back(make_pair(8'h12, 8'h34, 8'h56, 8'hff, 8'hfe, 8'hdc, 8'hba, 8'h00));
    pairs_to_send.push_back(make_pair(8'h12, 8'h34, 8'h56, 8'h00, 8'hfe, 8'hdc, 8'hba, 8'hff));
    pairs_to_send.push_back(make_pair(8'hff, 8'h00, 8'hff, 8'h01, 8'h00, 8'hff, 8'h00, 8'h01));
    pairs_to_send.push_back(make_pair(8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h01));
    pairs_to_send.push_back(make_pair(8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
    pairs_to_send.push_back(make_pair(8'hff, 8'hff, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80));
    pairs_to_send.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    pairs_to_send.push_back(make_pair(8'hfe, 8'h01, 8'h7f, 8'hfe, 8'h01, 8'hfe, 8'h80, 8'hff));
    pairs_to_send.push_back(make_pair(8'h55, 8'h55, 8'h55, 8'h7f, 8'haa, 8'haa, 8'haa, 8'hc8));
    pairs_to_send.push_back(make_pair(8'haa, 8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 8'h55));
    wait_idle();

    // Blending off: every field, alpha included, must pass the source through.
    write_blend(1'b0);
    @(negedge clk);
    pairs_to_send.push_back(make_pair(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
    pairs_to_send.push_back(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
    pairs_to_send.push_back(make_pair(8'h12, 8'h34, 8'h56, 8'h00, 8'h9a, 8'hbc, 8'hde, 8'hff));
    pairs_to_send.push_back(make_pair(8'haa, 8'h55, 8'hc3, 8'h80, 8'h55, 8'haa, 8'h3c, 8'h40));
    queue_random(120);
    wait_idle();

    // The bulk of the run with blending on, then short and long stretches
    // flipping between the two settings. Each pause drains the block fully.
    write_blend(1'b1);
    queue_random(250);
    wait_idle();
    write_blend(1'b0);
    queue_random(60);
    wait_idle();
    write_blend(1'b1);
    queue_random(150);
    wait_idle();

    $display("%0d pixel pairs sent (%0d with blending off), %0d results checked,",
             sent_count, copied_count, checked_count);
    $display("%0d writes of the blend switch, %0d mismatches", cfg_write_count,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
